@@ rtl/kinsoku_line_break_layout_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the layout core checker
// ----------------------------------------------------------------------------
`ifndef KINSOKU_LINE_BREAK_LAYOUT_CORE_DEFINES_SVH
`define KINSOKU_LINE_BREAK_LAYOUT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define KLB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define KLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/klb_pkg.sv @@
// ----------------------------------------------------------------------------
// klb_pkg
// Types, constants and code tables for the kinsoku line-break layout core.
// ----------------------------------------------------------------------------
`default_nettype none

package klb_pkg;

  localparam int GRID_COLS_DEF = 16;
  localparam int GRID_ROWS_DEF = 4;

  localparam int CODE_W      = 16;
  localparam int COL_IN_W    = 4;
  localparam int ROW_IN_W    = 3;
  localparam int CELL_W      = 7;
  localparam int MAX_RESULTS = 3;
  localparam int NUM_W       = 2;

  localparam logic [CODE_W-1:0] BLANK_CODE = 16'h0000;

  localparam int NO_START_N = 34;
  localparam int NO_END_N   = 5;

  // Codes that may not open a line
  localparam logic [CODE_W-1:0] NO_START_CODES [NO_START_N] = '{
    16'h82E1, 16'h82E3, 16'h82E5, 16'h82C1, 16'h8142, 16'h8141, 16'h8145, 16'h8163,
    16'h8184, 16'h8178, 16'h8176, 16'h816A, 16'h816E, 16'h8148, 16'h8149, 16'h817C,
    16'h815B, 16'h8383, 16'h8385, 16'h8387, 16'h8362, 16'h8396, 16'h829F, 16'h82A1,
    16'h82A3, 16'h82A5, 16'h82A7, 16'h8340, 16'h8342, 16'h8344, 16'h8346, 16'h8348,
    16'h8144, 16'h8160
  };

  // Opening brackets that may not close a line
  localparam logic [CODE_W-1:0] NO_END_CODES [NO_END_N] = '{
    16'h8183, 16'h8177, 16'h8175, 16'h816D, 16'h8169
  };

  typedef struct packed {
    logic [CODE_W-1:0]   char_code;
    logic                first_char;
    logic [COL_IN_W-1:0] start_col;
    logic [ROW_IN_W-1:0] start_row;
    logic                last_char;
  } item_t;

  typedef struct packed {
    logic no_start;
    logic no_end;
  } class_t;

  typedef struct packed {
    logic              write_valid;
    logic [CELL_W-1:0] cell_index;
    logic [CODE_W-1:0] cell_code;
    logic              run_end;
    logic              string_done;
    logic [CELL_W-1:0] cell_total;
    logic              overflow;
  } result_t;

  typedef struct packed {
    logic [NUM_W-1:0]                num;
    result_t [MAX_RESULTS-1:0]       res;
  } batch_t;

  typedef struct packed {
    logic ready;
    logic take;
  } queue_ctl_t;

  function automatic logic is_no_start(input logic [CODE_W-1:0] code);
    logic hit;
    int   i;
    hit = 1'b0;
    for (i = 0; i < NO_START_N; i++) begin
      hit = hit | (code == NO_START_CODES[i]);
    end
    return hit;
  endfunction

  function automatic logic is_no_end(input logic [CODE_W-1:0] code);
    logic hit;
    int   i;
    hit = 1'b0;
    for (i = 0; i < NO_END_N; i++) begin
      hit = hit | (code == NO_END_CODES[i]);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

@@ rtl/klb_class.sv @@
// ----------------------------------------------------------------------------
// klb_class
// Matches a character code against the line-start and line-end prohibition
// tables.
// ----------------------------------------------------------------------------
`default_nettype none

module klb_class (
  input  wire logic [klb_pkg::CODE_W-1:0] code,
  output klb_pkg::class_t                 cls
);

  always_comb begin
    cls.no_start = klb_pkg::is_no_start(code);
    cls.no_end   = klb_pkg::is_no_end(code);
  end

endmodule

`default_nettype wire

@@ rtl/klb_layout.sv @@
// ----------------------------------------------------------------------------
// klb_layout
// Cursor state and placement logic: turns one registered character into up to
// three cell writes and advances column, row, count and previous code.
// ----------------------------------------------------------------------------
`default_nettype none

module klb_layout #(
  parameter int GRID_COLS = klb_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = klb_pkg::GRID_ROWS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire klb_pkg::item_t  item,
  input  wire klb_pkg::class_t cls,
  output klb_pkg::batch_t     batch
);

  localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
  localparam int COL_MAX    = (GRID_COLS > 16) ? GRID_COLS : 16;
  localparam int COL_W      = $clog2(COL_MAX);
  localparam int ROW_MAX    = (GRID_ROWS + 1 > 8) ? GRID_ROWS + 1 : 8;
  localparam int ROW_W      = $clog2(ROW_MAX);
  localparam int CNT_W      = $clog2(GRID_CELLS + 2);
  localparam int WIDE_W     = (CNT_W > klb_pkg::CELL_W) ? CNT_W : klb_pkg::CELL_W;

  logic [COL_W-1:0]           cursor_col, cursor_col_next;
  logic [ROW_W-1:0]           cursor_row, cursor_row_next;
  logic [CNT_W-1:0]           cell_count, cell_count_next;
  logic [klb_pkg::CODE_W-1:0] prev_code,  prev_code_next;
  logic                       overflowed, overflowed_next;

  logic [COL_W-1:0]  eff_col;
  logic [ROW_W-1:0]  eff_row;
  logic [CNT_W-1:0]  eff_count;
  logic              eff_ovf;
  logic [COL_W:0]    col_inc;
  logic [WIDE_W-1:0] cnt_wide;
  int                k;

  always_comb begin
    // a first character reloads the start position before anything else
    eff_col   = item.first_char ? COL_W'(item.start_col) : cursor_col;
    eff_row   = item.first_char ? ROW_W'(item.start_row) : cursor_row;
    eff_count = item.first_char ? '0 : cell_count;
    eff_ovf   = item.first_char ? 1'b0 : overflowed;

    overflowed_next = eff_ovf || (eff_count >= CNT_W'(GRID_CELLS)) ||
                      (eff_row >= ROW_W'(GRID_ROWS));

    col_inc  = {1'b0, eff_col} + (COL_W+1)'(1);
    cnt_wide = WIDE_W'(eff_count);

    cursor_col_next = eff_col;
    cursor_row_next = eff_row;
    cell_count_next = eff_count;
    prev_code_next  = prev_code;
    batch           = '0;

    if (overflowed_next) begin
      batch.num = klb_pkg::NUM_W'(1);
    end else if (eff_col == '0 && eff_count != '0 && cls.no_start) begin
      // pull the previous character down with the prohibited starter
      batch.num                = klb_pkg::NUM_W'(3);
      batch.res[0].write_valid = 1'b1;
      batch.res[0].cell_index  = klb_pkg::CELL_W'(cnt_wide - WIDE_W'(1));
      batch.res[0].cell_code   = klb_pkg::BLANK_CODE;
      batch.res[1].write_valid = 1'b1;
      batch.res[1].cell_index  = klb_pkg::CELL_W'(cnt_wide);
      batch.res[1].cell_code   = prev_code;
      batch.res[2].write_valid = 1'b1;
      batch.res[2].cell_index  = klb_pkg::CELL_W'(cnt_wide + WIDE_W'(1));
      batch.res[2].cell_code   = item.char_code;
      cursor_col_next          = COL_W'(2);
      cell_count_next          = eff_count + CNT_W'(2);
      prev_code_next           = item.char_code;
    end else if (eff_col == COL_W'(GRID_COLS - 1) && cls.no_end) begin
      // pad the last column and open the next row with the bracket
      batch.num                = klb_pkg::NUM_W'(2);
      batch.res[0].write_valid = 1'b1;
      batch.res[0].cell_index  = klb_pkg::CELL_W'(cnt_wide);
      batch.res[0].cell_code   = klb_pkg::BLANK_CODE;
      batch.res[1].write_valid = 1'b1;
      batch.res[1].cell_index  = klb_pkg::CELL_W'(cnt_wide + WIDE_W'(1));
      batch.res[1].cell_code   = item.char_code;
      cursor_row_next          = eff_row + ROW_W'(1);
      cursor_col_next          = COL_W'(1);
      cell_count_next          = eff_count + CNT_W'(2);
      prev_code_next           = item.char_code;
    end else begin
      batch.num                = klb_pkg::NUM_W'(1);
      batch.res[0].write_valid = 1'b1;
      batch.res[0].cell_index  = klb_pkg::CELL_W'(cnt_wide);
      batch.res[0].cell_code   = item.char_code;
      cell_count_next          = eff_count + CNT_W'(1);
      prev_code_next           = item.char_code;
      if (col_inc >= (COL_W+1)'(GRID_COLS)) begin
        cursor_col_next = '0;
        cursor_row_next = eff_row + ROW_W'(1);
      end else begin
        cursor_col_next = col_inc[COL_W-1:0];
      end
    end

    for (k = 0; k < klb_pkg::MAX_RESULTS; k++) begin
      if (klb_pkg::NUM_W'(k) < batch.num) begin
        batch.res[k].overflow = overflowed_next;
      end
      if (klb_pkg::NUM_W'(k) == batch.num - klb_pkg::NUM_W'(1)) begin
        batch.res[k].run_end     = 1'b1;
        batch.res[k].string_done = item.last_char;
        batch.res[k].cell_total  = item.last_char ?
          klb_pkg::CELL_W'(WIDE_W'(cell_count_next)) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      cell_count <= '0;
      prev_code  <= '0;
      overflowed <= 1'b0;
    end else if (take) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      cell_count <= cell_count_next;
      prev_code  <= prev_code_next;
      overflowed <= overflowed_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/klb_out_queue.sv @@
// ----------------------------------------------------------------------------
// klb_out_queue
// Result register: holds the up to three cell writes of one character and
// hands them out one beat per cycle while result_stall is low, head first.
// ----------------------------------------------------------------------------
`default_nettype none

module klb_out_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_full,
  input  wire klb_pkg::batch_t batch,
  output klb_pkg::queue_ctl_t ctl,
  output logic             result_valid,
  input  wire logic        result_stall,
  output klb_pkg::result_t head
);

  klb_pkg::result_t [klb_pkg::MAX_RESULTS-1:0] res;
  logic [klb_pkg::NUM_W-1:0]                   count;
  logic                                        deliver;

  assign result_valid = (count != '0);
  assign deliver      = result_valid && !result_stall;
  assign head         = res[0];

  // room for a new batch once the last beat of the current one leaves
  always_comb begin
    ctl.ready = (count == '0) || (count == klb_pkg::NUM_W'(1) && !result_stall);
    ctl.take  = item_full && ctl.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.take) begin
      count <= batch.num;
    end else if (deliver) begin
      count <= count - klb_pkg::NUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      res <= batch.res;
    end else if (deliver) begin
      // advance the next beat to the head
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

endmodule

`default_nettype wire

@@ rtl/kinsoku_line_break_layout_core.sv @@
// ----------------------------------------------------------------------------
// kinsoku_line_break_layout_core
// Lays out double-byte character codes on a text grid with line-start and
// line-end prohibition, one cell write per result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (char_valid / char_stall) takes one character per beat with
//   first_char, start_col, start_row and last_char marks. Output channel
//   (result_valid / result_stall) gives one result beat per cell write: one
//   for an ordinary character, two for an opening bracket in the last column,
//   three for a prohibited starter at column 0 with a cell before it, and a
//   single non-writing beat once the grid is full.
//   The first result beat of a character comes out of the result register,
//   which loads it from the input register. One character per cycle for
//   single-write characters while result_stall is low; otherwise the
//   character holds the result register until its last write leaves, one
//   beat per cycle on the output port while result_stall is low.
//   A stalled output keeps its beat; the input register still takes one more
//   character and then raises char_stall until the result register frees.
//   Reset clears the cursor, count, previous code and overflow flag and
//   empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kinsoku_line_break_layout_core #(
  parameter int GRID_COLS = klb_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = klb_pkg::GRID_ROWS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            char_valid,
  output logic                                 char_stall,
  input  wire logic [klb_pkg::CODE_W-1:0]      char_code,
  input  wire logic                            first_char,
  input  wire logic [klb_pkg::COL_IN_W-1:0]    start_col,
  input  wire logic [klb_pkg::ROW_IN_W-1:0]    start_row,
  input  wire logic                            last_char,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic                                 write_valid,
  output logic [klb_pkg::CELL_W-1:0]           cell_index,
  output logic [klb_pkg::CODE_W-1:0]           cell_code,
  output logic                                 run_end,
  output logic                                 string_done,
  output logic [klb_pkg::CELL_W-1:0]           cell_total,
  output logic                                 overflow
);

  klb_pkg::item_t      item;
  logic                item_full;
  logic                accept;
  klb_pkg::class_t     cls;
  klb_pkg::batch_t     batch;
  klb_pkg::queue_ctl_t ctl;
  klb_pkg::result_t    head;

  assign char_stall = item_full && !ctl.ready;
  assign accept     = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (accept) begin
      item_full <= 1'b1;
    end else if (ctl.take) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.char_code  <= char_code;
      item.first_char <= first_char;
      item.start_col  <= start_col;
      item.start_row  <= start_row;
      item.last_char  <= last_char;
    end
  end

  klb_class u_class (
    .code (item.char_code),
    .cls  (cls)
  );

  klb_layout #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_layout (
    .clk   (clk),
    .rst   (rst),
    .take  (ctl.take),
    .item  (item),
    .cls   (cls),
    .batch (batch)
  );

  klb_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .item_full    (item_full),
    .batch        (batch),
    .ctl          (ctl),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign write_valid = head.write_valid;
  assign cell_index  = head.cell_index;
  assign cell_code   = head.cell_code;
  assign run_end     = head.run_end;
  assign string_done = head.string_done;
  assign cell_total  = head.cell_total;
  assign overflow    = head.overflow;

endmodule

`default_nettype wire

@@ rtl/klb_checker.sv @@
// ----------------------------------------------------------------------------
// klb_checker
// Port-level checks on the layout core's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kinsoku_line_break_layout_core_defines.svh"

module klb_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       result_valid,
  input wire logic                       result_stall,
  input wire logic                       write_valid,
  input wire logic [klb_pkg::CELL_W-1:0] cell_index,
  input wire logic [klb_pkg::CODE_W-1:0] cell_code,
  input wire logic                       run_end,
  input wire logic                       string_done,
  input wire logic                       overflow
);

  `KLB_ASSERT_NEXT(a_valid_holds, result_valid && result_stall, result_valid, "result beat dropped while stalled")
  `KLB_ASSERT_NEXT(a_beat_holds, result_valid && result_stall, $stable(cell_index) && $stable(cell_code) && $stable(run_end), "stalled result beat changed")
  `KLB_ASSERT_NOW(a_ovf_no_write, result_valid && overflow, !write_valid, "cell written after overflow")
  `KLB_ASSERT_NOW(a_idle_single, result_valid && !write_valid, run_end && cell_index == '0 && cell_code == '0, "non-writing beat not a lone clean beat")
  `KLB_ASSERT_NOW(a_done_at_end, result_valid && string_done, run_end, "string done before last beat of character")

endmodule

bind kinsoku_line_break_layout_core klb_checker u_klb_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .write_valid  (write_valid),
  .cell_index   (cell_index),
  .cell_code    (cell_code),
  .run_end      (run_end),
  .string_done  (string_done),
  .overflow     (overflow)
);

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the kinsoku line-break layout core. Drives strings
// of character codes over the valid/stall input channel, predicts every cell
// write from its own cursor, count and previous-code state, and matches each
// result beat in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS         = 16;
  localparam int ROWS         = 4;
  localparam int TOTAL_ITEMS  = 200;
  localparam int CALM_TAIL    = 40;

  // Codes that may not open a line, and opening brackets that may not end one
  localparam logic [15:0] BARRED_START [34] = '{
    16'h82E1, 16'h82E3, 16'h82E5, 16'h82C1, 16'h8142, 16'h8141, 16'h8145, 16'h8163,
    16'h8184, 16'h8178, 16'h8176, 16'h816A, 16'h816E, 16'h8148, 16'h8149, 16'h817C,
    16'h815B, 16'h8383, 16'h8385, 16'h8387, 16'h8362, 16'h8396, 16'h829F, 16'h82A1,
    16'h82A3, 16'h82A5, 16'h82A7, 16'h8340, 16'h8342, 16'h8344, 16'h8346, 16'h8348,
    16'h8144, 16'h8160
  };
  localparam logic [15:0] BARRED_END [5] = '{
    16'h8183, 16'h8177, 16'h8175, 16'h816D, 16'h8169
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid;
  logic        char_stall;
  logic [15:0] char_code;
  logic        first_char;
  logic [3:0]  start_col;
  logic [2:0]  start_row;
  logic        last_char;
  logic        result_valid;
  logic        result_stall;
  logic        write_valid;
  logic [6:0]  cell_index;
  logic [15:0] cell_code;
  logic        run_end;
  logic        string_done;
  logic [6:0]  cell_total;
  logic        overflow;
  klb_pkg::result_t seen_beat;

  bit calm = 1'b0;
  int sent = 0;

  class cell_write_board;
    int unsigned cur_col;
    int unsigned cur_row;
    int unsigned laid_cells;
    logic [15:0] last_laid;
    bit          grid_full;
    klb_pkg::result_t due_writes[$];
    int          mismatches;
    int          beat_no;

    function new();
      cur_col    = 0;
      cur_row    = 0;
      laid_cells = 0;
      last_laid  = '0;
      grid_full  = 1'b0;
      mismatches = 0;
      beat_no    = 0;
    endfunction

    function klb_pkg::result_t write_of(int unsigned idx, logic [15:0] code);
      klb_pkg::result_t w;
      w = '0;
      w.write_valid = 1'b1;
      w.cell_index  = 7'(idx);
      w.cell_code   = code;
      return w;
    endfunction

    function void take_char(logic [15:0] code, bit first_mark, logic [3:0] col0,
                            logic [2:0] row0, bit last_mark);
      klb_pkg::result_t w [3];
      int      n;
      bit      bars_start;
      bit      bars_end;
      bars_start = 1'b0;
      bars_end   = 1'b0;
      foreach (BARRED_START[i]) if (BARRED_START[i] == code) bars_start = 1'b1;
      foreach (BARRED_END[i]) if (BARRED_END[i] == code) bars_end = 1'b1;
      w = '{default: '0};
      if (first_mark) begin
        cur_col    = col0;
        cur_row    = row0;
        laid_cells = 0;
        grid_full  = 1'b0;
      end
      if (!grid_full && (laid_cells >= COLS * ROWS || cur_row >= ROWS)) grid_full = 1'b1;
      if (grid_full) begin
        n = 1;
      end else if (cur_col == 0 && laid_cells != 0 && bars_start) begin
        // pull the previous character down, leaving a blank behind
        w[0] = write_of(laid_cells - 1, klb_pkg::BLANK_CODE);
        w[1] = write_of(laid_cells, last_laid);
        w[2] = write_of(laid_cells + 1, code);
        n = 3;
        cur_col = 2;
        laid_cells += 2;
        last_laid = code;
      end else if (cur_col == COLS - 1 && bars_end) begin
        w[0] = write_of(laid_cells, klb_pkg::BLANK_CODE);
        w[1] = write_of(laid_cells + 1, code);
        n = 2;
        cur_row++;
        cur_col = 1;
        laid_cells += 2;
        last_laid = code;
      end else begin
        w[0] = write_of(laid_cells, code);
        n = 1;
        laid_cells++;
        cur_col++;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        last_laid = code;
      end
      w[n-1].run_end     = 1'b1;
      w[n-1].string_done = last_mark;
      w[n-1].cell_total  = last_mark ? 7'(laid_cells) : 7'd0;
      for (int k = 0; k < n; k++) begin
        w[k].overflow = grid_full;
        due_writes.push_back(w[k]);
      end
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      $display("%0t: result beat %0d: %s got %0h want %0h", $realtime, beat_no, what, got,
               want);
    endtask

    task match_write(klb_pkg::result_t got);
      klb_pkg::result_t want;
      beat_no++;
      if (due_writes.size() == 0) begin
        report("beat with no character pending", 1, 0);
        return;
      end
      want = due_writes.pop_front();
      if (got.write_valid !== want.write_valid)
        report("write_valid", got.write_valid, want.write_valid);
      if (got.cell_index !== want.cell_index)
        report("cell_index", got.cell_index, want.cell_index);
      if (got.cell_code !== want.cell_code)
        report("cell_code", got.cell_code, want.cell_code);
      if (got.run_end !== want.run_end)
        report("run_end", got.run_end, want.run_end);
      if (got.string_done !== want.string_done)
        report("string_done", got.string_done, want.string_done);
      if (got.cell_total !== want.cell_total)
        report("cell_total", got.cell_total, want.cell_total);
      if (got.overflow !== want.overflow)
        report("overflow", got.overflow, want.overflow);
    endtask
  endclass

  cell_write_board oracle;

  kinsoku_line_break_layout_core u_top (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .first_char   (first_char),
    .start_col    (start_col),
    .start_row    (start_row),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .write_valid  (write_valid),
    .cell_index   (cell_index),
    .cell_code    (cell_code),
    .run_end      (run_end),
    .string_done  (string_done),
    .cell_total   (cell_total),
    .overflow     (overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign seen_beat = {write_valid, cell_index, cell_code, run_end, string_done, cell_total,
                      overflow};

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) oracle.match_write(seen_beat);
  end

  // Output side: alternate stall bursts with free-running stretches
  initial begin : result_pacing
    int span;
    result_stall = 1'b0;
    forever begin
      if (calm || rst) begin
        result_stall = 1'b0;
        @(negedge clk);
      end else begin
        result_stall = ($urandom_range(0, 2) == 0);
        span = result_stall ? $urandom_range(1, 18) : $urandom_range(1, 40);
        repeat (span) @(negedge clk);
      end
    end
  end

  function automatic logic [15:0] pick_code();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return BARRED_START[$urandom_range(0, 33)];
    if (roll < 45) return BARRED_END[$urandom_range(0, 4)];
    if (roll < 48) return 16'h0000;
    if (roll < 50) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  // Present one character at a falling edge and hold it until the beat is taken
  task automatic send_char(input logic [15:0] code, input bit first_mark,
                           input logic [3:0] col0, input logic [2:0] row0,
                           input bit last_mark);
    calm = (sent >= TOTAL_ITEMS - CALM_TAIL);
    if (!calm && $urandom_range(0, 3) == 0) begin
      char_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    char_valid = 1'b1;
    char_code  = code;
    first_char = first_mark;
    start_col  = col0;
    start_row  = row0;
    last_char  = last_mark;
    do @(posedge clk); while (char_stall);
    oracle.take_char(code, first_mark, col0, row0, last_mark);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    int          length;
    logic [3:0]  s_col;
    logic [2:0]  s_row;
    oracle     = new();
    char_valid = 1'b0;
    char_code  = '0;
    first_char = 1'b0;
    start_col  = '0;
    start_row  = '0;
    last_char  = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // carry on from the reset cursor with no start mark
    send_char(16'hFFFF, 0, 4'd0, 3'd0, 0);
    send_char(BARRED_START[5], 0, 4'd0, 3'd0, 0);
    send_char(16'h0000, 1, 4'd15, 3'd0, 0);
    // line starter at column 0 drags the previous code down
    send_char(BARRED_START[0], 0, 4'd0, 3'd0, 0);
    send_char(16'h1234, 0, 4'd0, 3'd0, 1);
    // line starter at column 0 of an empty string is laid out plainly
    send_char(BARRED_START[33], 1, 4'd0, 3'd2, 0);
    send_char(BARRED_END[0], 1, 4'd15, 3'd1, 0);
    send_char(BARRED_END[1], 0, 4'd0, 3'd0, 0);
    send_char(16'h8000, 1, 4'd14, 3'd0, 0);
    send_char(BARRED_END[4], 0, 4'd0, 3'd0, 0);
    send_char(BARRED_START[16], 0, 4'd0, 3'd0, 1);
    // run off the bottom of the grid, then keep feeding the dead string
    send_char(16'h7FFF, 1, 4'd14, 3'd3, 0);
    send_char(16'h5555, 0, 4'd0, 3'd0, 0);
    send_char(BARRED_START[20], 0, 4'd0, 3'd0, 0);
    send_char(16'hAAAA, 0, 4'd0, 3'd0, 1);
    send_char(16'h0101, 0, 4'd0, 3'd0, 1);
    send_char(16'hFFFF, 1, 4'd7, 3'd4, 1);
    send_char(16'h0041, 1, 4'd0, 3'd0, 1);
    send_char(BARRED_END[2], 1, 4'd15, 3'd3, 0);
    send_char(BARRED_END[3], 0, 4'd0, 3'd0, 1);
    send_char(BARRED_START[10], 1, 4'd10, 3'd2, 0);

    while (sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(pick_code(), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  3'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          // long string from near the top: wraps, slides and can fill the grid
          length = $urandom_range(40, 72);
          s_col  = 4'($urandom_range(0, 3));
          s_row  = 3'd0;
        end else begin
          length = $urandom_range(1, 16);
          s_col  = 4'($urandom_range(0, 15));
          s_row  = ($urandom_range(0, 9) == 0) ? 3'd4 : 3'($urandom_range(0, 3));
        end
        for (int i = 0; i < length; i++) begin
          send_char(pick_code(), i == 0, (i == 0) ? s_col : 4'($urandom_range(0, 15)),
                    (i == 0) ? s_row : 3'($urandom_range(0, 4)), i == length - 1);
        end
      end
    end
    char_valid = 1'b0;

    while (oracle.due_writes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (oracle.mismatches == 0 && oracle.due_writes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
